### rtl/csaa_pkg.sv
// ----------------------------------------------------------------------------
// csaa_pkg
// Shared widths, constants, codes and the arctangent table for the cone and
// sphere arc angle pipeline.
// ----------------------------------------------------------------------------
package csaa_pkg;

  localparam int LEN_W        = 32;
  localparam int DIR_W        = 32;
  localparam int TAN_W        = 31;
  localparam int ANG_W        = 31;
  localparam int D_RW         = 32;
  localparam int P_RW         = 62;
  localparam int X_RW         = 31;
  localparam int R_W          = 34;
  localparam int DEN_W        = 59;
  localparam int FRAC_STEPS   = 30;
  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_W     = 34;
  localparam int Z_W          = 33;
  localparam int NARROW_BITS  = 29;

  localparam logic [ANG_W-1:0] ONE_Q30     = 31'd1073741824;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;

  typedef enum logic [1:0] {
    OUT_INTERSECT = 2'd0,
    OUT_SEPARATE  = 2'd1,
    OUT_CONTAINED = 2'd2,
    OUT_NEGATIVE  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    FIX_NONE    = 2'd0,
    FIX_ZERO    = 2'd1,
    FIX_HALF_PI = 2'd2
  } fix_t;

  typedef struct packed {
    outcome_t code;
    fix_t     fix;
  } tag_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    tag_t             tag;
  } heron_side_t;

  function automatic logic [Z_W-1:0] atan_q30(input int unsigned i);
    logic [Z_W-1:0] v;
    case (i)
      0:  v = 33'd843314857;
      1:  v = 33'd497837829;
      2:  v = 33'd263043837;
      3:  v = 33'd133525159;
      4:  v = 33'd67021687;
      5:  v = 33'd33543516;
      6:  v = 33'd16775851;
      7:  v = 33'd8388437;
      8:  v = 33'd4194283;
      9:  v = 33'd2097149;
      10: v = 33'd1048576;
      11: v = 33'd524288;
      12: v = 33'd262144;
      13: v = 33'd131072;
      14: v = 33'd65536;
      15: v = 33'd32768;
      16: v = 33'd16384;
      17: v = 33'd8192;
      18: v = 33'd4096;
      19: v = 33'd2048;
      20: v = 33'd1024;
      21: v = 33'd512;
      22: v = 33'd256;
      23: v = 33'd128;
      24: v = 33'd64;
      25: v = 33'd32;
      26: v = 33'd16;
      27: v = 33'd8;
      28: v = 33'd4;
      29: v = 33'd2;
      30: v = 33'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/csaa_isqrt.sv
// ----------------------------------------------------------------------------
// csaa_isqrt
// Pipelined floor square root, one root bit per stage, with sideband data
// carried alongside each item.
// ----------------------------------------------------------------------------
module csaa_isqrt #(
  parameter int RW = csaa_pkg::D_RW,
  parameter int SW = csaa_pkg::R_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  logic            vld_r  [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rest_r [RW];
  logic [SW-1:0]   side_r [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic            pv;
    logic [RW+1:0]   prem;
    logic [RW-1:0]   proot;
    logic [2*RW-1:0] prest;
    logic [SW-1:0]   pside;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            take;

    if (j == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prest = in_rad;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld_r[j-1];
      assign prem  = rem_r[j-1];
      assign proot = root_r[j-1];
      assign prest = rest_r[j-1];
      assign pside = side_r[j-1];
    end

    assign rem_sh = {prem, prest[2*RW-1 -: 2]};
    assign trial  = {2'b00, proot, 2'b01};
    assign diff   = rem_sh - trial;
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= take ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_r[j] <= {proot[RW-2:0], take};
        rest_r[j] <= {prest[2*RW-3:0], 2'b00};
        side_r[j] <= pside;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

### rtl/csaa_front.sv
// ----------------------------------------------------------------------------
// csaa_front
// Projection front end: dot product, axial distance, radicand of the
// perpendicular distance and the cone circle radius.
// ----------------------------------------------------------------------------
module csaa_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_center_dir_x,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_center_dir_y,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_center_dir_z,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_momentum_x,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_momentum_y,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_momentum_z,
  input  logic [csaa_pkg::TAN_W-1:0]         in_tan_half_angle,
  input  logic [csaa_pkg::LEN_W-1:0]         in_center_distance,
  output logic                               out_valid,
  output logic [2*csaa_pkg::D_RW-1:0]        out_rad,
  output logic signed [csaa_pkg::R_W-1:0]    out_r
);
  import csaa_pkg::*;

  logic signed [63:0] p0, p1, p2;
  logic signed [35:0] sum;
  logic signed [31:0] dot_nxt;
  logic signed [32:0] dist_s;
  logic signed [64:0] lprod;
  logic signed [65:0] lsq;
  logic [63:0]        dsq;
  logic signed [31:0] tan_s;
  logic signed [64:0] rprod;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [33:0] t0_r, t1_r, t2_r;
  logic [TAN_W-1:0]   tan1_r, tan2_r, tan3_r;
  logic [LEN_W-1:0]   dist1_r, dist2_r, dist3_r;
  logic signed [31:0] dot_r;
  logic signed [32:0] l_r;
  logic [63:0]        dsq_r, lsq_r;
  logic signed [R_W-1:0] r4_r, r5_r;
  logic [63:0]        rad_r;

  assign p0 = in_center_dir_x * in_momentum_x;
  assign p1 = in_center_dir_y * in_momentum_y;
  assign p2 = in_center_dir_z * in_momentum_z;

  always_comb begin
    sum = 36'(t0_r) + 36'(t1_r) + 36'(t2_r);
    if (sum > 36'sd1073741824) begin
      dot_nxt = 32'sd1073741824;
    end else if (sum < -36'sd1073741824) begin
      dot_nxt = -32'sd1073741824;
    end else begin
      dot_nxt = sum[31:0];
    end
  end

  assign dist_s = $signed({1'b0, dist2_r});
  assign lprod  = dot_r * dist_s;
  assign lsq    = l_r * l_r;
  assign dsq    = 64'(dist3_r) * 64'(dist3_r);
  assign tan_s  = $signed({1'b0, tan3_r});
  assign rprod  = tan_s * l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r    <= p0[63:30];
      t1_r    <= p1[63:30];
      t2_r    <= p2[63:30];
      tan1_r  <= in_tan_half_angle;
      dist1_r <= in_center_distance;
      dot_r   <= dot_nxt;
      tan2_r  <= tan1_r;
      dist2_r <= dist1_r;
      l_r     <= lprod[62:30];
      tan3_r  <= tan2_r;
      dist3_r <= dist2_r;
      dsq_r   <= dsq;
      lsq_r   <= lsq[63:0];
      r4_r    <= rprod[63:30];
      rad_r   <= (dsq_r > lsq_r) ? (dsq_r - lsq_r) : '0;
      r5_r    <= r4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_rad   = rad_r;
  assign out_r     = r5_r;

endmodule

### rtl/csaa_heron.sv
// ----------------------------------------------------------------------------
// csaa_heron
// Case split, narrowing shift, Heron factors, their 124-bit product and the
// divisor of the sine.
// ----------------------------------------------------------------------------
module csaa_heron (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [csaa_pkg::D_RW-1:0]       in_d,
  input  logic signed [csaa_pkg::R_W-1:0] in_r,
  input  logic [csaa_pkg::LEN_W-1:0]      sphere_radius,
  output logic                            out_valid,
  output logic [2*csaa_pkg::P_RW-1:0]     out_prod,
  output csaa_pkg::heron_side_t           out_side
);
  import csaa_pkg::*;

  // stage 1: case split and maximum
  logic signed [35:0] r_x, big_r_x, d_x, diff_x, absd_x, mr_x, m_x;
  logic sep, cont;

  assign r_x     = 36'(in_r);
  assign big_r_x = $signed({4'b0, sphere_radius});
  assign d_x     = $signed({4'b0, in_d});
  assign diff_x  = r_x - big_r_x;
  assign absd_x  = diff_x[35] ? -diff_x : diff_x;
  assign sep     = d_x >= (r_x + big_r_x);
  assign cont    = d_x <= absd_x;
  assign mr_x    = (r_x > big_r_x) ? r_x : big_r_x;
  assign m_x     = (d_x > mr_x) ? d_x : mr_x;

  logic v1_r, sep1_r, cont1_r;
  logic signed [R_W-1:0] r1_r;
  logic [LEN_W-1:0] br1_r;
  logic [D_RW-1:0]  d1_r;
  logic [33:0]      m1_r;

  // stage 2: narrowing shift
  logic [2:0] k;
  logic signed [R_W-1:0] rs;
  logic [LEN_W-1:0] brs;
  logic [D_RW-1:0]  ds;

  always_comb begin
    k = 3'd5;
    for (int kk = 4; kk >= 0; kk--) begin
      if ((m1_r >> (NARROW_BITS + kk)) == '0) begin
        k = 3'(kk);
      end
    end
  end

  assign rs  = r1_r >>> k;
  assign brs = br1_r >> k;
  assign ds  = d1_r >> k;

  logic v2_r, sep2_r, cont2_r;
  logic [NARROW_BITS-1:0] rr2_r, br2_r, dd2_r;

  // stage 3: Heron factors
  logic signed [31:0] rr_z, br_z, dd_z;
  assign rr_z = $signed({3'b0, rr2_r});
  assign br_z = $signed({3'b0, br2_r});
  assign dd_z = $signed({3'b0, dd2_r});

  logic v3_r, sep3_r, cont3_r;
  logic signed [31:0] a3_r, b3_r, c3_r, e3_r;
  logic [NARROW_BITS-1:0] rr3_r, dd3_r;

  // stage 4: checks and magnitudes
  logic zero, neg, den_zero;
  logic signed [31:0] b_abs, c_abs, e_abs;
  tag_t tag4;

  assign zero     = (a3_r == '0) || (b3_r == '0) || (c3_r == '0) || (e3_r == '0);
  assign neg      = b3_r[31] ^ c3_r[31] ^ e3_r[31] ^ a3_r[31];
  assign den_zero = (rr3_r == '0) || (dd3_r == '0);
  assign b_abs    = b3_r[31] ? -b3_r : b3_r;
  assign c_abs    = c3_r[31] ? -c3_r : c3_r;
  assign e_abs    = e3_r[31] ? -e3_r : e3_r;

  always_comb begin
    priority if (sep3_r) begin
      tag4 = '{code: OUT_SEPARATE, fix: FIX_ZERO};
    end else if (cont3_r) begin
      tag4 = '{code: OUT_CONTAINED, fix: FIX_ZERO};
    end else if (zero) begin
      tag4 = '{code: OUT_INTERSECT, fix: FIX_ZERO};
    end else if (neg) begin
      tag4 = '{code: OUT_NEGATIVE, fix: FIX_ZERO};
    end else if (den_zero) begin
      tag4 = '{code: OUT_INTERSECT, fix: FIX_ZERO};
    end else begin
      tag4 = '{code: OUT_INTERSECT, fix: FIX_NONE};
    end
  end

  logic v4_r;
  tag_t tag4_r;
  logic [30:0] a4_r, b4_r, c4_r, e4_r;
  logic [NARROW_BITS-1:0] rr4_r, dd4_r;

  // stage 5: factor pairs and divisor
  logic v5_r;
  heron_side_t side5_r;
  logic [61:0] ab5_r, ce5_r;

  // stage 6: partial products
  logic v6_r;
  heron_side_t side6_r;
  logic [61:0] pll6_r, plh6_r, phl6_r, phh6_r;

  // stage 7: middle sum
  logic v7_r;
  heron_side_t side7_r;
  logic [61:0] pll7_r, phh7_r;
  logic [62:0] mid7_r;

  // stage 8: full product
  logic v8_r;
  heron_side_t side8_r;
  logic [2*P_RW-1:0] prod8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sep1_r  <= sep;
      cont1_r <= cont;
      r1_r    <= in_r;
      br1_r   <= sphere_radius;
      d1_r    <= in_d;
      m1_r    <= m_x[33:0];

      sep2_r  <= sep1_r;
      cont2_r <= cont1_r;
      rr2_r   <= rs[NARROW_BITS-1:0];
      br2_r   <= brs[NARROW_BITS-1:0];
      dd2_r   <= ds[NARROW_BITS-1:0];

      sep3_r  <= sep2_r;
      cont3_r <= cont2_r;
      a3_r    <= rr_z + br_z + dd_z;
      b3_r    <= br_z + dd_z - rr_z;
      c3_r    <= rr_z + dd_z - br_z;
      e3_r    <= rr_z + br_z - dd_z;
      rr3_r   <= rr2_r;
      dd3_r   <= dd2_r;

      tag4_r  <= tag4;
      a4_r    <= a3_r[30:0];
      b4_r    <= b_abs[30:0];
      c4_r    <= c_abs[30:0];
      e4_r    <= e_abs[30:0];
      rr4_r   <= rr3_r;
      dd4_r   <= dd3_r;

      side5_r.tag <= tag4_r;
      side5_r.den <= {58'(dd4_r) * 58'(rr4_r), 1'b0};
      ab5_r       <= 62'(a4_r) * 62'(b4_r);
      ce5_r       <= 62'(c4_r) * 62'(e4_r);

      side6_r <= side5_r;
      pll6_r  <= 62'(ab5_r[30:0]) * 62'(ce5_r[30:0]);
      plh6_r  <= 62'(ab5_r[30:0]) * 62'(ce5_r[61:31]);
      phl6_r  <= 62'(ab5_r[61:31]) * 62'(ce5_r[30:0]);
      phh6_r  <= 62'(ab5_r[61:31]) * 62'(ce5_r[61:31]);

      side7_r <= side6_r;
      pll7_r  <= pll6_r;
      phh7_r  <= phh6_r;
      mid7_r  <= 63'(plh6_r) + 63'(phl6_r);

      side8_r <= side7_r;
      prod8_r <= {phh7_r, 62'b0} + {30'b0, mid7_r, 31'b0} + {62'b0, pll7_r};
    end
  end

  assign out_valid = v8_r;
  assign out_prod  = prod8_r;
  assign out_side  = side8_r;

endmodule

### rtl/csaa_div.sv
// ----------------------------------------------------------------------------
// csaa_div
// Pipelined fractional divide: sine argument S / den in Q1.30, one quotient
// bit per stage, saturated at one.
// ----------------------------------------------------------------------------
module csaa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [csaa_pkg::P_RW-1:0]     in_s,
  input  logic [csaa_pkg::DEN_W-1:0]    in_den,
  input  csaa_pkg::tag_t                in_tag,
  output logic                          out_valid,
  output logic [csaa_pkg::ANG_W-1:0]    out_x,
  output csaa_pkg::tag_t                out_tag
);
  import csaa_pkg::*;

  localparam int NS = FRAC_STEPS + 1;

  logic                  vld_r [NS];
  logic                  sat_r [NS];
  logic [DEN_W-1:0]      rem_r [NS];
  logic [DEN_W-1:0]      den_r [NS];
  logic [FRAC_STEPS-1:0] q_r   [NS];
  tag_t                  tag_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= in_s >= P_RW'(in_den);
      rem_r[0] <= in_s[DEN_W-1:0];
      den_r[0] <= in_den;
      q_r[0]   <= '0;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_step
    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] diff;
    logic           take;

    assign rem_sh = {rem_r[j-1], 1'b0};
    assign diff   = rem_sh - {1'b0, den_r[j-1]};
    assign take   = rem_sh >= {1'b0, den_r[j-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[j] <= sat_r[j-1];
        rem_r[j] <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= {q_r[j-1][FRAC_STEPS-2:0], take};
        tag_r[j] <= tag_r[j-1];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_x     = sat_r[NS-1] ? ONE_Q30 : ANG_W'(q_r[NS-1]);
  assign out_tag   = tag_r[NS-1];

endmodule

### rtl/csaa_cordic.sv
// ----------------------------------------------------------------------------
// csaa_cordic
// Vectoring CORDIC, one micro-rotation per stage, that turns (cos, sin) of
// the half arc into its angle.
// ----------------------------------------------------------------------------
module csaa_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [csaa_pkg::X_RW-1:0]      in_cx,
  input  logic [csaa_pkg::ANG_W-1:0]     in_cy,
  input  csaa_pkg::tag_t                 in_tag,
  output logic                           out_valid,
  output logic signed [csaa_pkg::Z_W-1:0] out_z,
  output csaa_pkg::tag_t                 out_tag
);
  import csaa_pkg::*;

  localparam int NS = CORDIC_STEPS;

  logic                       vld_r [NS];
  logic signed [CORDIC_W-1:0] x_r   [NS];
  logic signed [CORDIC_W-1:0] y_r   [NS];
  logic signed [Z_W-1:0]      z_r   [NS];
  tag_t                       tag_r [NS];

  for (genvar j = 0; j < NS; j++) begin : g_rot
    localparam logic signed [Z_W-1:0] ATAN = atan_q30(j);

    logic                       pv;
    logic signed [CORDIC_W-1:0] px, py;
    logic signed [Z_W-1:0]      pz;
    tag_t                       ptag;
    logic signed [CORDIC_W-1:0] dx, dy;

    if (j == 0) begin : g_first
      assign pv   = in_valid;
      assign px   = $signed(CORDIC_W'(in_cx));
      assign py   = $signed(CORDIC_W'(in_cy));
      assign pz   = '0;
      assign ptag = in_tag;
    end else begin : g_next
      assign pv   = vld_r[j-1];
      assign px   = x_r[j-1];
      assign py   = y_r[j-1];
      assign pz   = z_r[j-1];
      assign ptag = tag_r[j-1];
    end

    assign dx = py >>> j;
    assign dy = px >>> j;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (py > 0) begin
          x_r[j] <= px + dx;
          y_r[j] <= py - dy;
          z_r[j] <= pz + ATAN;
        end else begin
          x_r[j] <= px - dx;
          y_r[j] <= py + dy;
          z_r[j] <= pz - ATAN;
        end
        tag_r[j] <= ptag;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_z     = z_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

### rtl/cone_sphere_arc_angle_top.sv
// ----------------------------------------------------------------------------
// cone_sphere_arc_angle_top
// Half arc angle where a cone circle crosses a sphere's circle, per voxel.
//
// Channels: in_* carries one voxel (center direction, momentum, tangent of
// the cone half angle, center distance); out_* returns the arc angle (Q1.30)
// and an outcome code. cfg_* writes the sphere radius; cfg_ready is always
// high. The user must write the radius only while no item is in flight;
// the block does not enforce it. An input transfer reaches out_valid
// through 5 projection stages, a 32-stage square root, 8 Heron stages, a
// 62-stage square root, a 31-stage divide, 2 stages of cosine setup, a
// 31-stage square root, 31 CORDIC stages and the output register; the
// 62-bit root of the Heron product is the longest of these.
// Throughput is one item per cycle while the receiver takes results; all
// stages advance together whenever the output register is empty or being
// taken, so in_ready follows that.
// Reset clears every valid bit and sets the radius to zero.
// ----------------------------------------------------------------------------
module cone_sphere_arc_angle_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_center_dir_x,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_center_dir_y,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_center_dir_z,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_momentum_x,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_momentum_y,
  input  logic signed [csaa_pkg::DIR_W-1:0]  in_momentum_z,
  input  logic [csaa_pkg::TAN_W-1:0]         in_tan_half_angle,
  input  logic [csaa_pkg::LEN_W-1:0]         in_center_distance,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [csaa_pkg::ANG_W-1:0]         out_arc_angle,
  output logic [1:0]                         out_outcome,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csaa_pkg::LEN_W-1:0]         cfg_sphere_radius
);
  import csaa_pkg::*;

  localparam int XS_W = ANG_W + $bits(tag_t);

  logic adv;
  logic [LEN_W-1:0] sphere_radius_r;

  logic                  fr_valid;
  logic [2*D_RW-1:0]     fr_rad;
  logic signed [R_W-1:0] fr_r;

  logic              sd_valid;
  logic [D_RW-1:0]   sd_root;
  logic [R_W-1:0]    sd_side;

  logic              hr_valid;
  logic [2*P_RW-1:0] hr_prod;
  heron_side_t       hr_side;

  logic                     sp_valid;
  logic [P_RW-1:0]          sp_root;
  logic [$bits(heron_side_t)-1:0] sp_side;
  heron_side_t              sp_hs;

  logic             dv_valid;
  logic [ANG_W-1:0] dv_x;
  tag_t             dv_tag;

  logic             p1_valid_r, p2_valid_r;
  logic [ANG_W-1:0] x1_r, x2_r;
  logic [2*X_RW-2:0] xx1_r;
  logic [2*X_RW-1:0] crad2_r;
  tag_t             tag1_nxt, tag1_r, tag2_r;

  logic             sx_valid;
  logic [X_RW-1:0]  sx_root;
  logic [XS_W-1:0]  sx_side;

  logic                  co_valid;
  logic signed [Z_W-1:0] co_z;
  tag_t                  co_tag;

  logic             out_valid_r;
  logic [ANG_W-1:0] arc_nxt, arc_r;
  logic [1:0]       outcome_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sphere_radius_r <= '0;
    end else if (cfg_valid) begin
      sphere_radius_r <= cfg_sphere_radius;
    end
  end

  csaa_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (adv),
    .in_valid           (in_valid),
    .in_center_dir_x    (in_center_dir_x),
    .in_center_dir_y    (in_center_dir_y),
    .in_center_dir_z    (in_center_dir_z),
    .in_momentum_x      (in_momentum_x),
    .in_momentum_y      (in_momentum_y),
    .in_momentum_z      (in_momentum_z),
    .in_tan_half_angle  (in_tan_half_angle),
    .in_center_distance (in_center_distance),
    .out_valid          (fr_valid),
    .out_rad            (fr_rad),
    .out_r              (fr_r)
  );

  csaa_isqrt #(.RW(D_RW), .SW(R_W)) u_sqrt_d (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_side   (fr_r),
    .out_valid (sd_valid),
    .out_root  (sd_root),
    .out_side  (sd_side)
  );

  csaa_heron u_heron (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .in_valid      (sd_valid),
    .in_d          (sd_root),
    .in_r          ($signed(sd_side)),
    .sphere_radius (sphere_radius_r),
    .out_valid     (hr_valid),
    .out_prod      (hr_prod),
    .out_side      (hr_side)
  );

  csaa_isqrt #(.RW(P_RW), .SW($bits(heron_side_t))) u_sqrt_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (hr_valid),
    .in_rad    (hr_prod),
    .in_side   (hr_side),
    .out_valid (sp_valid),
    .out_root  (sp_root),
    .out_side  (sp_side)
  );

  assign sp_hs = heron_side_t'(sp_side);

  csaa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sp_valid),
    .in_s      (sp_root),
    .in_den    (sp_hs.den),
    .in_tag    (sp_hs.tag),
    .out_valid (dv_valid),
    .out_x     (dv_x),
    .out_tag   (dv_tag)
  );

  always_comb begin
    tag1_nxt = dv_tag;
    if (dv_tag.fix == FIX_NONE) begin
      if (dv_x == '0) begin
        tag1_nxt.fix = FIX_ZERO;
      end else if (dv_x >= ONE_Q30) begin
        tag1_nxt.fix = FIX_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= dv_valid;
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= dv_x;
      xx1_r   <= (2*X_RW-1)'(dv_x) * (2*X_RW-1)'(dv_x);
      tag1_r  <= tag1_nxt;
      x2_r    <= x1_r;
      crad2_r <= (62'd1 << 60) - (2*X_RW)'(xx1_r);
      tag2_r  <= tag1_r;
    end
  end

  csaa_isqrt #(.RW(X_RW), .SW(XS_W)) u_sqrt_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (p2_valid_r),
    .in_rad    (crad2_r),
    .in_side   ({x2_r, tag2_r}),
    .out_valid (sx_valid),
    .out_root  (sx_root),
    .out_side  (sx_side)
  );

  csaa_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sx_valid),
    .in_cx     (sx_root),
    .in_cy     (sx_side[XS_W-1 -: ANG_W]),
    .in_tag    (tag_t'(sx_side[$bits(tag_t)-1:0])),
    .out_valid (co_valid),
    .out_z     (co_z),
    .out_tag   (co_tag)
  );

  always_comb begin
    unique case (co_tag.fix)
      FIX_ZERO:    arc_nxt = '0;
      FIX_HALF_PI: arc_nxt = HALF_PI_Q30;
      default: begin
        if (co_z[Z_W-1]) begin
          arc_nxt = '0;
        end else if (co_z > $signed({2'b00, HALF_PI_Q30})) begin
          arc_nxt = HALF_PI_Q30;
        end else begin
          arc_nxt = co_z[ANG_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= co_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arc_r     <= arc_nxt;
      outcome_r <= co_tag.code;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_arc_angle = arc_r;
  assign out_outcome   = outcome_r;

endmodule

### rtl/csaa_checker.sv
// ----------------------------------------------------------------------------
// csaa_checker
// Port-level checks on the arc angle block, bound to the top level.
// ----------------------------------------------------------------------------
module csaa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [csaa_pkg::ANG_W-1:0]   out_arc_angle,
  input logic [1:0]                   out_outcome
);
  import csaa_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_arc_angle)
      && $stable(out_outcome))
    else $error("stalled result changed");

  a_no_angle_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome != OUT_INTERSECT) |-> out_arc_angle == '0)
    else $error("nonzero angle without intersection");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_arc_angle <= HALF_PI_Q30)
    else $error("angle above half pi");

endmodule

bind cone_sphere_arc_angle_top csaa_checker u_csaa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_arc_angle (out_arc_angle),
  .out_outcome   (out_outcome)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks cone_sphere_arc_angle_top against a bit-exact predictor of the arc
// angle and outcome code. Directed geometry first, then random voxels under
// several sphere radii and handshake idling patterns; every result is
// compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import csaa_pkg::*;

  localparam int  IDLE_LIMIT = 5000;
  localparam int  DRAIN_CYC  = 210;
  localparam longint ONE     = 64'sd1073741824;
  localparam longint HALF_PI = 64'sd1686629713;

  typedef struct {
    logic signed [31:0] cx, cy, cz, px, py, pz;
    logic [30:0]        tan_h;
    logic [31:0]        c_dist;
  } voxel_t;

  typedef struct {
    logic [30:0] angle;
    outcome_t    code;
  } arc_t;

  localparam longint ATAN_TBL [31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1};

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_center_dir_x = 0, in_center_dir_y = 0, in_center_dir_z = 0;
  logic signed [31:0] in_momentum_x = 0, in_momentum_y = 0, in_momentum_z = 0;
  logic [30:0] in_tan_half_angle = 0;
  logic [31:0] in_center_distance = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [30:0] out_arc_angle;
  logic [1:0] out_outcome;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_sphere_radius = 0;

  logic [31:0] radius_model = 0;
  arc_t        pending_arcs[$];
  int          mismatches = 0;
  int          idle_mode = 0;
  int          stall_cnt = 0;

  cone_sphere_arc_angle_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_center_dir_x(in_center_dir_x), .in_center_dir_y(in_center_dir_y),
    .in_center_dir_z(in_center_dir_z), .in_momentum_x(in_momentum_x),
    .in_momentum_y(in_momentum_y), .in_momentum_z(in_momentum_z),
    .in_tan_half_angle(in_tan_half_angle), .in_center_distance(in_center_distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_arc_angle(out_arc_angle), .out_outcome(out_outcome),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_sphere_radius(cfg_sphere_radius)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] root;
    logic [67:0] rem, trial;
    root = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | 68'(v[2*i +: 2]);
      trial = {2'b0, root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint arcsine_q30(logic [63:0] x);
    longint cx, cy, z, dx, dy;
    if (x == 0) return 0;
    if (x >= 64'(ONE)) return HALF_PI;
    cx = longint'(floor_sqrt(128'((64'd1 << 60) - x * x)));
    cy = longint'(x);
    z = 0;
    for (int i = 0; i < 31; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; z += ATAN_TBL[i];
      end else begin
        cx -= dx; cy += dy; z -= ATAN_TBL[i];
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI) z = HALF_PI;
    return z;
  endfunction

  function automatic arc_t predict_arc(voxel_t v, logic [31:0] rad);
    arc_t res;
    longint dot, l, d, r, sr, m, rr, sr_n, dd, a, b, c, e, diff;
    logic [63:0] dist_w, la, dsq, lsq, den, ab, ce, s_root, q, rem, sinq;
    int k;
    bit neg;
    res.angle = 0;
    dot = ((longint'(v.cx) * longint'(v.px)) >>> 30)
        + ((longint'(v.cy) * longint'(v.py)) >>> 30)
        + ((longint'(v.cz) * longint'(v.pz)) >>> 30);
    if (dot > ONE) dot = ONE;
    if (dot < -ONE) dot = -ONE;
    dist_w = {32'b0, v.c_dist};
    l = (dot * longint'(dist_w)) >>> 30;
    la = (l < 0) ? 64'(-l) : 64'(l);
    dsq = dist_w * dist_w;
    lsq = la * la;
    d = longint'(floor_sqrt({64'b0, (dsq > lsq) ? dsq - lsq : 64'd0}));
    r = (longint'({33'b0, v.tan_h}) * l) >>> 30;
    sr = longint'({32'b0, rad});
    if (d >= r + sr) begin
      res.code = OUT_SEPARATE;
      return res;
    end
    diff = (r > sr) ? r - sr : sr - r;
    if (d <= diff) begin
      res.code = OUT_CONTAINED;
      return res;
    end
    m = r;
    if (sr > m) m = sr;
    if (d > m) m = d;
    k = 0;
    while ((m >>> k) >= 64'sd536870912) k++;
    rr = r >>> k;
    sr_n = sr >>> k;
    dd = d >>> k;
    a = rr + sr_n + dd;
    b = sr_n + dd - rr;
    c = rr + dd - sr_n;
    e = rr + sr_n - dd;
    res.code = OUT_INTERSECT;
    if (a == 0 || b == 0 || c == 0 || e == 0) return res;
    neg = 0;
    if (a < 0) begin neg ^= 1; a = -a; end
    if (b < 0) begin neg ^= 1; b = -b; end
    if (c < 0) begin neg ^= 1; c = -c; end
    if (e < 0) begin neg ^= 1; e = -e; end
    if (neg) begin
      res.code = OUT_NEGATIVE;
      return res;
    end
    den = 64'(2 * dd * rr);
    if (den == 0) return res;
    ab = 64'(a) * 64'(b);
    ce = 64'(c) * 64'(e);
    s_root = floor_sqrt({64'b0, ab} * {64'b0, ce});
    if (s_root >= den) begin
      sinq = 64'(ONE);
    end else begin
      q = 0;
      rem = s_root;
      for (int i = 0; i < 30; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q = q | 64'd1;
        end
      end
      sinq = q;
    end
    res.angle = 31'(arcsine_q30(sinq));
    return res;
  endfunction

  // random unit vector, Q2.30
  task automatic unit_vec(output logic signed [31:0] x, y, z);
    real a, b, c, n;
    n = 0;
    while (n < 1.0e-3) begin
      a = $urandom_range(0, 2000000) / 1.0e6 - 1.0;
      b = $urandom_range(0, 2000000) / 1.0e6 - 1.0;
      c = $urandom_range(0, 2000000) / 1.0e6 - 1.0;
      n = $sqrt(a * a + b * b + c * c);
    end
    x = $rtoi(a / n * 1073741824.0);
    y = $rtoi(b / n * 1073741824.0);
    z = $rtoi(c / n * 1073741824.0);
  endtask

  function automatic logic signed [31:0] any_dir();
    return $signed($urandom_range(32'h8000_0000, 0)) - 32'sd1073741824;
  endfunction

  task automatic random_voxel(output voxel_t v, input bit shaped);
    real base, scaled;
    if (shaped) begin
      unit_vec(v.cx, v.cy, v.cz);
      unit_vec(v.px, v.py, v.pz);
      base = (radius_model == 0) ? real'($urandom >> $urandom_range(0, 31))
                                 : real'(radius_model);
      scaled = base * ($urandom_range(300, 3000) / 1000.0) + 1.0;
      if (scaled > 4294967295.0) scaled = 4294967295.0;
      v.c_dist = 32'(longint'(scaled));
      v.tan_h = 31'($urandom >> $urandom_range(1, 5));
    end else begin
      v.cx = any_dir(); v.cy = any_dir(); v.cz = any_dir();
      v.px = any_dir(); v.py = any_dir(); v.pz = any_dir();
      v.tan_h = 31'($urandom);
      v.c_dist = $urandom >> $urandom_range(0, 8);
    end
  endtask

  function automatic int sender_gap_pct();
    return (idle_mode == 1) ? 79 : (idle_mode == 3) ? 30 : 0;
  endfunction

  // call at a falling edge; returns at a falling edge after the transfer
  task automatic send_voxel(voxel_t v);
    while ($urandom_range(99, 0) < sender_gap_pct()) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_center_dir_x <= v.cx; in_center_dir_y <= v.cy; in_center_dir_z <= v.cz;
    in_momentum_x <= v.px; in_momentum_y <= v.py; in_momentum_z <= v.pz;
    in_tan_half_angle <= v.tan_h;
    in_center_distance <= v.c_dist;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    pending_arcs.push_back(predict_arc(v, radius_model));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_arcs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_radius(logic [31:0] rad);
    wait_drained();
    cfg_sphere_radius <= rad;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    radius_model = rad;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_geom(real theta_deg, real tan_r, real dist_r);
    voxel_t v;
    real t;
    t = theta_deg * 3.14159265358979 / 180.0;
    v.cx = 32'sd1073741824; v.cy = 0; v.cz = 0;
    v.px = $rtoi($cos(t) * 1073741824.0);
    v.py = $rtoi($sin(t) * 1073741824.0);
    v.pz = 0;
    v.tan_h = 31'(longint'(tan_r * 1073741824.0));
    v.c_dist = 32'(longint'(dist_r * 256.0));
    send_voxel(v);
  endtask

  task automatic test_directed();
    voxel_t v;
    v = '{0, 0, 0, 0, 0, 0, 0, 0};
    send_voxel(v);
    v = '{32'sd1073741824, 32'sd1073741824, 32'sd1073741824,
          32'sd1073741824, 32'sd1073741824, 32'sd1073741824, 31'h7FFF_FFFF, 32'hFFFF_FFFF};
    send_voxel(v);
    v = '{-32'sd1073741824, -32'sd1073741824, -32'sd1073741824,
          32'sd1073741824, 32'sd1073741824, 32'sd1073741824, 31'h7FFF_FFFF, 32'hFFFF_FFFF};
    send_voxel(v);
    write_radius(32'd2560);
    send_geom(45.0, 1.0, 20.0);
    send_geom(30.0, 0.5, 20.0);
    send_geom(60.0, 2.0, 15.0);
    send_geom(90.0, 1.0, 20.0);
    send_geom(0.0, 1.0, 20.0);
    send_geom(180.0, 1.0, 20.0);
    send_geom(45.0, 0.01, 100.0);
    send_geom(10.0, 0.1, 5.0);
    send_geom(45.0, 1.0, 0.0);
    send_geom(135.0, 1.0, 20.0);
    send_geom(45.0, 1.9, 1000000.0);
    send_geom(44.0, 1.0, 14.5);
    write_radius(32'hFFFF_FFFF);
    send_geom(45.0, 1.9, 16000000.0);
    send_geom(30.0, 1.0, 16777215.0);
    send_geom(60.0, 0.8, 12000000.0);
    write_radius(32'h3000_0000);
    send_geom(45.0, 1.0, 2200000.0);
    send_geom(40.0, 1.2, 3000000.0);
  endtask

  task automatic test_random(logic [31:0] rad, int mode, int count);
    voxel_t v;
    write_radius(rad);
    idle_mode = mode;
    repeat (count) begin
      random_voxel(v, $urandom_range(99, 0) < 85);
      send_voxel(v);
    end
  endtask

  task automatic test_pause(logic [31:0] rad, int count);
    voxel_t v;
    write_radius(rad);
    idle_mode = 0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        in_valid <= 0;
        while (pending_arcs.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      random_voxel(v, 1);
      send_voxel(v);
    end
  endtask

  always @(negedge clk) begin
    case (idle_mode)
      2: out_ready <= ($urandom_range(99, 0) >= 79);
      3: out_ready <= ($urandom_range(99, 0) >= 30);
      default: out_ready <= 1;
    endcase
  end

  always @(posedge clk) begin
    arc_t exp_arc;
    if (rst_n && out_valid && out_ready) begin
      if (pending_arcs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: angle %0d outcome %0d",
                                       out_arc_angle, out_outcome);
      end else begin
        exp_arc = pending_arcs.pop_front();
        if (out_arc_angle !== exp_arc.angle || out_outcome !== exp_arc.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %0d got %0d, outcome exp %0d got %0d",
                     exp_arc.angle, out_arc_angle, exp_arc.code, out_outcome);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_directed();
    test_random(32'd2560, 0, 80);
    test_random(32'd1, 1, 60);
    test_random(32'hFFFF_FFFF, 2, 60);
    test_random($urandom >> $urandom_range(0, 20), 3, 80);
    test_pause(32'h3000_0000, 60);
    test_random(32'd0, 3, 60);
    test_random(32'd40000, 2, 50);
    wait_drained();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
